>>> rtl/rwed_pkg.sv
// shared types and constants for the release wave event detector
package rwed_pkg;

  localparam int TimeW  = 24;
  localparam int LevelW = 16;
  localparam int IndexW = 2;
  localparam int DataW  = 24;

  localparam logic [TimeW-1:0]  SkipReset  = TimeW'(150);
  localparam logic [LevelW-1:0] QuietReset = LevelW'(655);
  localparam logic [LevelW-1:0] WaveReset  = LevelW'(2294);

  typedef enum logic [IndexW-1:0] {
    REG_SKIP  = 2'd0,
    REG_QUIET = 2'd1,
    REG_WAVE  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [TimeW-1:0]  skip_until_time;
    logic [LevelW-1:0] quiet_level;
    logic [LevelW-1:0] wave_level;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]  time_stamp;
    logic [LevelW-1:0] open_fraction;
    logic              last_sample;
  } sample_t;

  typedef struct packed {
    logic              wave_found;
    logic [TimeW-1:0]  start_time;
    logic [TimeW-1:0]  peak_time;
    logic [TimeW-1:0]  end_time;
    logic [LevelW-1:0] peak_level;
  } result_t;

endpackage

>>> rtl/release_wave_event_detector_core.sv
// top level of the release wave event detector
//
//  channel   direction  handshake            payload
//  input     in         in_valid/in_stall    time_stamp, open_fraction, last_sample
//  output    out        out_valid/out_stall  wave_found, start_time, peak_time,
//                                            end_time, peak_level
//  config    in         write_enable         reg_index, write_data
//
// one sample per cycle while in_stall is low; a sample is registered, then its
// state update and any report are done when it leaves the input register, so a
// report reaches the outputs through the input and result registers in turn.
// reset clears the tracking state and loads the default thresholds.
// a waiting report stalls only a following last sample, and new samples wait behind it; other samples flow on.
module release_wave_event_detector_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rwed_pkg::TimeW-1:0]    time_stamp,
  input  logic [rwed_pkg::LevelW-1:0]   open_fraction,
  input  logic                          last_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          wave_found,
  output logic [rwed_pkg::TimeW-1:0]    start_time,
  output logic [rwed_pkg::TimeW-1:0]    peak_time,
  output logic [rwed_pkg::TimeW-1:0]    end_time,
  output logic [rwed_pkg::LevelW-1:0]   peak_level,
  input  logic                          write_enable,
  input  logic [rwed_pkg::IndexW-1:0]   reg_index,
  input  logic [rwed_pkg::DataW-1:0]    write_data
);

  rwed_pkg::cfg_t    cfg;
  rwed_pkg::sample_t in_sample, s1_sample;
  rwed_pkg::result_t result_next, result;
  logic              s1_valid, go, out_free;

  assign in_sample.time_stamp    = time_stamp;
  assign in_sample.open_fraction = open_fraction;
  assign in_sample.last_sample   = last_sample;

  assign go = s1_valid && (!s1_sample.last_sample || out_free);

  rwed_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .cfg          (cfg)
  );

  rwed_input_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .go        (go),
    .s1_valid  (s1_valid),
    .s1_sample (s1_sample)
  );

  rwed_tracker u_track (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .go          (go),
    .s1_sample   (s1_sample),
    .result_next (result_next)
  );

  rwed_output_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (go && s1_sample.last_sample),
    .result_next (result_next),
    .out_free    (out_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (result)
  );

  assign wave_found = result.wave_found;
  assign start_time = result.start_time;
  assign peak_time  = result.peak_time;
  assign end_time   = result.end_time;
  assign peak_level = result.peak_level;

endmodule

>>> rtl/rwed_cfg_regs.sv
// configuration registers with write port
module rwed_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           write_enable,
  input  logic [rwed_pkg::IndexW-1:0]    reg_index,
  input  logic [rwed_pkg::DataW-1:0]     write_data,
  output rwed_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.skip_until_time <= rwed_pkg::SkipReset;
      cfg.quiet_level     <= rwed_pkg::QuietReset;
      cfg.wave_level      <= rwed_pkg::WaveReset;
    end else if (write_enable) begin
      case (reg_index)
        rwed_pkg::REG_SKIP:  cfg.skip_until_time <= write_data[rwed_pkg::TimeW-1:0];
        rwed_pkg::REG_QUIET: cfg.quiet_level     <= write_data[rwed_pkg::LevelW-1:0];
        rwed_pkg::REG_WAVE:  cfg.wave_level      <= write_data[rwed_pkg::LevelW-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/rwed_input_reg.sv
// input register stage for sample transactions
module rwed_input_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rwed_pkg::sample_t in_sample,
  input  logic              go,
  output logic              s1_valid,
  output rwed_pkg::sample_t s1_sample
);

  assign in_stall = s1_valid && !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample <= in_sample;
    end
  end

endmodule

>>> rtl/rwed_tracker.sv
// wave detection state and per-sample update
module rwed_tracker (
  input  logic              clk,
  input  logic              rst,
  input  rwed_pkg::cfg_t    cfg,
  input  logic              go,
  input  rwed_pkg::sample_t s1_sample,
  output rwed_pkg::result_t result_next
);

  logic                        armed, confirmed, ended;
  logic [rwed_pkg::TimeW-1:0]  initiation_time, max_time, finish_time;
  logic [rwed_pkg::LevelW-1:0] max_level;

  logic                        armed_next, confirmed_next, ended_next;
  logic [rwed_pkg::TimeW-1:0]  initiation_time_next, max_time_next, finish_time_next;
  logic [rwed_pkg::LevelW-1:0] max_level_next;

  logic                        proc, above_quiet, below_quiet, above_wave;
  logic                        armed_mid;

  always_comb begin
    proc        = s1_sample.time_stamp > cfg.skip_until_time;
    above_quiet = s1_sample.open_fraction > cfg.quiet_level;
    below_quiet = s1_sample.open_fraction < cfg.quiet_level;
    above_wave  = s1_sample.open_fraction > cfg.wave_level;

    initiation_time_next = initiation_time;
    max_time_next        = max_time;
    finish_time_next     = finish_time;
    max_level_next       = max_level;
    ended_next           = ended;
    armed_mid            = armed;

    // arm on a rise above quiet
    if (proc && above_quiet && !confirmed && !armed) begin
      initiation_time_next = s1_sample.time_stamp;
      armed_mid            = 1'b1;
    end
    armed_next = armed_mid;
    if (proc && armed_mid && below_quiet && !confirmed) begin
      armed_next = 1'b0;
    end
    confirmed_next = confirmed || (proc && above_wave && armed_next);

    // peak tracking until the end
    if (proc && confirmed_next && !ended) begin
      if (s1_sample.open_fraction > max_level) begin
        max_level_next = s1_sample.open_fraction;
        max_time_next  = s1_sample.time_stamp;
      end
      if (below_quiet) begin
        finish_time_next = s1_sample.time_stamp;
        ended_next       = 1'b1;
      end
    end

    result_next.wave_found = confirmed_next;
    result_next.start_time = confirmed_next ? initiation_time_next : '0;
    result_next.peak_time  = confirmed_next ? max_time_next : '0;
    result_next.end_time   = (confirmed_next && ended_next) ? finish_time_next : '0;
    result_next.peak_level = confirmed_next ? max_level_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed           <= 1'b0;
      confirmed       <= 1'b0;
      ended           <= 1'b0;
      initiation_time <= '0;
      max_time        <= '0;
      finish_time     <= '0;
      max_level       <= '0;
    end else if (go) begin
      if (s1_sample.last_sample) begin
        armed           <= 1'b0;
        confirmed       <= 1'b0;
        ended           <= 1'b0;
        initiation_time <= '0;
        max_time        <= '0;
        finish_time     <= '0;
        max_level       <= '0;
      end else begin
        armed           <= armed_next;
        confirmed       <= confirmed_next;
        ended           <= ended_next;
        initiation_time <= initiation_time_next;
        max_time        <= max_time_next;
        finish_time     <= finish_time_next;
        max_level       <= max_level_next;
      end
    end
  end

endmodule

>>> rtl/rwed_output_reg.sv
// result register for report transactions
module rwed_output_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  rwed_pkg::result_t result_next,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_stall,
  output rwed_pkg::result_t result
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule
